FILE: rtl/core/symbol_frequency_table_sort_core_assert.svh
// Assertion macros shared by the symbol frequency table core.
`ifndef SYMBOL_FREQUENCY_TABLE_SORT_CORE_ASSERT_SVH
`define SYMBOL_FREQUENCY_TABLE_SORT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFTS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFTS_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/sfts_pkg.sv
// Types and constants of the symbol frequency table core.
`timescale 1ns / 1ps
package sfts_pkg;
  localparam int unsigned SYM_BITS       = 8;
  localparam int unsigned OUT_COUNT_BITS = 32;
  localparam int unsigned TOTAL_BITS     = 9;
  localparam logic [SYM_BITS-1:0] SYM_SIGN = 8'h80;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_SORT = 2'd1,
    KIND_READ = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SORT = 1'b1
  } state_e;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic                add;
    logic                append;
    logic                sort;
    logic                phase;
    logic [SYM_BITS-1:0] sym;
  } cell_cmd_t;
endpackage

FILE: rtl/core/symbol_frequency_table_sort_core.sv
// Top level of the symbol frequency table with in-place sort.
//
// Usage: drive kind_i, symbol_i and position_i with start_i high; the item
// is taken at the clock edge where start_i is high and busy_o is low.
// Each item gives one result beat: done_o is high for exactly one cycle
// with out_symbol_o, out_count_o, distinct_symbols_o and entry_valid_o.
// The receiver cannot stall; a beat not taken in its cycle is gone.
// Add, read and ignored kinds: result in the cycle after acceptance, and
// a new item can be taken every cycle. Each slot compares its own symbol
// and bumps its own count, so an add needs no search across the table.
// Sort: busy_o stays high while the passes run, one odd-even transposition
// pass across the row of cells per cycle; the result beat follows the last
// pass, and the next item is taken in that cycle.
// Reset empties the table (entry count zero); slot contents are not
// cleared since only slots below the entry count are ever read.
`timescale 1ns / 1ps
module symbol_frequency_table_sort_core #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          kind_i,
  input  logic signed [sfts_pkg::SYM_BITS-1:0] symbol_i,
  input  logic [7:0]                          position_i,
  output logic                                done_o,
  output logic signed [sfts_pkg::SYM_BITS-1:0] out_symbol_o,
  output logic [sfts_pkg::OUT_COUNT_BITS-1:0] out_count_o,
  output logic [sfts_pkg::TOTAL_BITS-1:0]     distinct_symbols_o,
  output logic                                entry_valid_o
);
  import sfts_pkg::*;

  `include "symbol_frequency_table_sort_core_assert.svh"

  localparam int unsigned N  = TABLE_ENTRIES;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned PW = $clog2(N);
  localparam logic [CW-1:0] FULL     = CW'(N);
  localparam logic [PW-1:0] LAST_PASS = PW'(N - 1);

  state_e              state_q, state_d;
  logic [CW-1:0]       total_q, total_d;
  logic [PW-1:0]       pass_q, pass_d;
  logic                accept;
  kind_e               kind;
  cell_cmd_t           cmd;

  logic [SYM_BITS-1:0]   c_sym [N];
  logic [COUNT_BITS-1:0] c_cnt [N];
  logic [COUNT_BITS-1:0] c_nxt [N];
  logic                  c_hit [N];
  logic                  c_swp [N];

  logic                  found;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [SYM_BITS-1:0]   rd_sym;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_valid;

  logic                  done_q, done_d;
  logic [SYM_BITS-1:0]   rsym_q, rsym_d;
  logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;
  logic                  rval_q, rval_d;
  logic [COUNT_BITS+OUT_COUNT_BITS-1:0] cnt_ext;

  assign accept = start_i && (state_q == ST_IDLE);
  assign kind   = kind_e'(kind_i);

  // Broadcast command to the row
  always_comb begin
    cmd.add    = accept && (kind == KIND_ADD);
    cmd.append = cmd.add && !found && (total_q < FULL);
    cmd.sort   = (state_q == ST_SORT);
    cmd.phase  = pass_q[0];
    cmd.sym    = symbol_i;
  end

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [SYM_BITS-1:0]   l_sym, r_sym;
    logic [COUNT_BITS-1:0] l_cnt, r_cnt;
    logic                  l_swp;
    if (i == 0) begin : g_first
      assign l_sym = '0;
      assign l_cnt = '0;
      assign l_swp = 1'b0;
    end else begin : g_mid
      assign l_sym = c_sym[i-1];
      assign l_cnt = c_cnt[i-1];
      assign l_swp = c_swp[i-1];
    end
    if (i == N - 1) begin : g_last
      assign r_sym = '0;
      assign r_cnt = '0;
    end else begin : g_inner
      assign r_sym = c_sym[i+1];
      assign r_cnt = c_cnt[i+1];
    end
    sfts_cell #(
      .COUNT_BITS(COUNT_BITS),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .total_i    (total_q),
      .left_sym_i (l_sym),
      .left_cnt_i (l_cnt),
      .swap_l_i   (l_swp),
      .right_sym_i(r_sym),
      .right_cnt_i(r_cnt),
      .swap_r_o   (c_swp[i]),
      .hit_o      (c_hit[i]),
      .cnt_next_o (c_nxt[i]),
      .sym_o      (c_sym[i]),
      .cnt_o      (c_cnt[i])
    );
  end

  // Gather hit and read selections across the row
  always_comb begin
    found    = 1'b0;
    hit_cnt  = '0;
    rd_sym   = '0;
    rd_cnt   = '0;
    rd_valid = 1'b0;
    for (int unsigned i = 0; i < N; i++) begin
      if (c_hit[i]) begin
        found   = 1'b1;
        hit_cnt = hit_cnt | c_nxt[i];
      end
      if ((CW'(i) < total_q) && ({1'b0, position_i} == 9'(i))) begin
        rd_valid = 1'b1;
        rd_sym   = rd_sym | c_sym[i];
        rd_cnt   = rd_cnt | c_cnt[i];
      end
    end
  end

  // Sequence items and form the result beat
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    pass_d  = pass_q;
    done_d  = 1'b0;
    rsym_d  = rsym_q;
    rcnt_d  = rcnt_q;
    rval_d  = rval_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_ADD: begin
              done_d = 1'b1;
              rsym_d = symbol_i;
              if (found) begin
                rcnt_d = hit_cnt;
                rval_d = 1'b1;
              end else if (total_q < FULL) begin
                rcnt_d  = COUNT_BITS'(1);
                rval_d  = 1'b1;
                total_d = total_q + CW'(1);
              end else begin
                rcnt_d = '0;
                rval_d = 1'b0;
              end
            end
            KIND_READ: begin
              done_d = 1'b1;
              rsym_d = rd_sym;
              rcnt_d = rd_cnt;
              rval_d = rd_valid;
            end
            KIND_SORT: begin
              state_d = ST_SORT;
              pass_d  = '0;
            end
            default: begin
              done_d = 1'b1;
              rsym_d = '0;
              rcnt_d = '0;
              rval_d = 1'b0;
            end
          endcase
        end
      end
      ST_SORT: begin
        pass_d = pass_q + PW'(1);
        if (pass_q == LAST_PASS) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          rsym_d  = '0;
          rcnt_d  = '0;
          rval_d  = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      pass_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      pass_q  <= pass_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsym_q <= rsym_d;
    rcnt_q <= rcnt_d;
    rval_q <= rval_d;
  end

  // Drive outputs
  assign cnt_ext            = {{OUT_COUNT_BITS{1'b0}}, rcnt_q};
  assign busy_o             = (state_q == ST_SORT);
  assign done_o             = done_q;
  assign out_symbol_o       = rsym_q;
  assign out_count_o        = cnt_ext[OUT_COUNT_BITS-1:0];
  assign distinct_symbols_o = TOTAL_BITS'(total_q);
  assign entry_valid_o      = rval_q;

  `SFTS_ASSERT(a_total_le_full, clk_i, rst_ni, total_q <= FULL, "entry count beyond table")
  `SFTS_ASSERT(a_quick_done, clk_i, rst_ni, (accept && (kind != KIND_SORT)) |=> done_o, "missing result beat")
  `SFTS_ASSERT(a_sort_busy, clk_i, rst_ni, (accept && (kind == KIND_SORT)) |=> (busy_o && !done_o), "sort not started")
  `SFTS_ASSERT(a_sort_quiet, clk_i, rst_ni, (busy_o && (pass_q != LAST_PASS)) |=> !done_o, "early sort beat")
  `SFTS_ASSERT(a_sort_total, clk_i, rst_ni, busy_o |=> $stable(total_q), "entry count moved in sort")
endmodule

FILE: rtl/core/sfts_cell.sv
// One table slot: symbol and count, local count update and neighbor swap.
`timescale 1ns / 1ps
module sfts_cell #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned CW         = 9,
  parameter int unsigned IDX        = 0
) (
  input  logic                         clk_i,
  input  sfts_pkg::cell_cmd_t          cmd_i,
  input  logic [CW-1:0]                total_i,
  input  logic [sfts_pkg::SYM_BITS-1:0] left_sym_i,
  input  logic [COUNT_BITS-1:0]        left_cnt_i,
  input  logic                         swap_l_i,
  input  logic [sfts_pkg::SYM_BITS-1:0] right_sym_i,
  input  logic [COUNT_BITS-1:0]        right_cnt_i,
  output logic                         swap_r_o,
  output logic                         hit_o,
  output logic [COUNT_BITS-1:0]        cnt_next_o,
  output logic [sfts_pkg::SYM_BITS-1:0] sym_o,
  output logic [COUNT_BITS-1:0]        cnt_o
);
  import sfts_pkg::*;

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam logic          MY_PAR   = 1'(IDX % 2);

  logic [SYM_BITS-1:0]   sym_q, sym_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  valid, right_valid, right_first;
  logic [COUNT_BITS-1:0] cnt_inc;

  // Match and saturating increment
  assign valid   = MY_IDX < total_i;
  assign hit_o   = valid && (sym_q == cmd_i.sym);
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign cnt_next_o = cnt_inc;

  // Compare with right neighbor: lower count first, then lower signed symbol
  assign right_valid = NEXT_IDX < total_i;
  assign right_first = (right_cnt_i < cnt_q) ||
                       ((right_cnt_i == cnt_q) &&
                        ((right_sym_i ^ SYM_SIGN) < (sym_q ^ SYM_SIGN)));
  assign swap_r_o = cmd_i.sort && (cmd_i.phase == MY_PAR) && right_valid && right_first;

  // Pick next slot contents
  always_comb begin
    sym_d = sym_q;
    cnt_d = cnt_q;
    priority if (cmd_i.add && hit_o) begin
      cnt_d = cnt_inc;
    end else if (cmd_i.append && (total_i == MY_IDX)) begin
      sym_d = cmd_i.sym;
      cnt_d = COUNT_BITS'(1);
    end else if (swap_r_o) begin
      sym_d = right_sym_i;
      cnt_d = right_cnt_i;
    end else if (swap_l_i) begin
      sym_d = left_sym_i;
      cnt_d = left_cnt_i;
    end else begin
      sym_d = sym_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    cnt_q <= cnt_d;
  end

  assign sym_o = sym_q;
  assign cnt_o = cnt_q;
endmodule

FILE: dv/symbol_frequency_table_sort_core_tb.sv
// Self-checking testbench for the symbol frequency table with in-place sort.
`timescale 1ns / 1ps
module symbol_frequency_table_sort_core_tb;
  import sfts_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [1:0]           kind_i;
  logic signed [7:0]    symbol_i;
  logic [7:0]           position_i;
  logic                 done_o;
  logic signed [7:0]    out_symbol_o;
  logic [31:0]          out_count_o;
  logic [8:0]           distinct_symbols_o;
  logic                 entry_valid_o;

  symbol_frequency_table_sort_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .symbol_i          (symbol_i),
    .position_i        (position_i),
    .done_o            (done_o),
    .out_symbol_o      (out_symbol_o),
    .out_count_o       (out_count_o),
    .distinct_symbols_o(distinct_symbols_o),
    .entry_valid_o     (entry_valid_o)
  );

  typedef struct {
    logic signed [7:0] sym;
    logic [31:0]       cnt;
    logic [8:0]        total;
    logic              valid;
  } tally_t;

  typedef struct {
    kind_e             kind;
    logic signed [7:0] sym;
    logic [7:0]        pos;
    bit                typed;
    tally_t            want;
  } row_t;

  // Predictor copy of the table
  logic signed [7:0]       tbl_sym [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]   tbl_cnt [TABLE_ENTRIES];
  int unsigned             tbl_total;

  tally_t      pending_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_add, n_sort, n_read, n_nop, n_beats;
  int unsigned send_idle_pct;

  // Work out the beat for one item and update the table copy
  function automatic tally_t count_item(kind_e kind, logic signed [7:0] sym, logic [7:0] pos);
    tally_t r;
    bit found;
    int j;
    logic signed [7:0] ks;
    logic [COUNT_BITS-1:0] kc;
    r = '{sym: 8'sd0, cnt: 32'd0, total: 9'd0, valid: 1'b0};
    found = 0;
    case (kind)
      KIND_ADD: begin
        r.sym = sym;
        for (int i = 0; i < tbl_total && !found; i++) begin
          if (tbl_sym[i] == sym) begin
            if (tbl_cnt[i] != COUNT_TOP) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
            r.cnt = tbl_cnt[i][31:0];
            r.valid = 1'b1;
            found = 1;
          end
        end
        if (!found && tbl_total < TABLE_ENTRIES) begin
          tbl_sym[tbl_total] = sym;
          tbl_cnt[tbl_total] = 1;
          tbl_total++;
          r.cnt = 32'd1;
          r.valid = 1'b1;
        end
      end
      KIND_SORT: begin
        // Insertion sort: ascending count, then smaller signed symbol
        for (int i = 1; i < tbl_total; i++) begin
          kc = tbl_cnt[i];
          ks = tbl_sym[i];
          j = i;
          while (j > 0 && (kc < tbl_cnt[j-1] || (kc == tbl_cnt[j-1] && ks < tbl_sym[j-1])))
          begin
            tbl_cnt[j] = tbl_cnt[j-1];
            tbl_sym[j] = tbl_sym[j-1];
            j--;
          end
          tbl_cnt[j] = kc;
          tbl_sym[j] = ks;
        end
      end
      KIND_READ: begin
        if (pos < tbl_total) begin
          r.sym = tbl_sym[pos];
          r.cnt = tbl_cnt[pos][31:0];
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = tbl_total[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    tally_t w;
    if (rst_ni && done_o) begin
      n_beats++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("[%0t] unexpected result beat", $time);
      end else begin
        w = pending_q.pop_front();
        if (out_symbol_o !== w.sym) report_mismatch("out_symbol", out_symbol_o, w.sym);
        if (out_count_o !== w.cnt) report_mismatch("out_count", out_count_o, w.cnt);
        if (distinct_symbols_o !== w.total)
          report_mismatch("distinct_symbols", distinct_symbols_o, w.total);
        if (entry_valid_o !== w.valid) report_mismatch("entry_valid", entry_valid_o, w.valid);
      end
    end
  end

  // Drive one item, hold it until taken, then queue its expected beat
  task automatic send_item(kind_e kind, logic signed [7:0] sym, logic [7:0] pos,
                           bit typed, tally_t want);
    tally_t got;
    if ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    kind_i     <= kind;
    symbol_i   <= sym;
    position_i <= pos;
    start_i    <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    got = count_item(kind, sym, pos);
    pending_q.push_back(typed ? want : got);
    case (kind)
      KIND_ADD:  n_add++;
      KIND_SORT: n_sort++;
      KIND_READ: n_read++;
      default:   n_nop++;
    endcase
  endtask

  function automatic row_t mk(kind_e k, int s, int p, bit t, int ws, int wc, int wt, int wv);
    row_t r;
    r.kind = k;
    r.sym = s[7:0];
    r.pos = p[7:0];
    r.typed = t;
    r.want = '{sym: ws[7:0], cnt: wc, total: wt[8:0], valid: wv[0]};
    return r;
  endfunction

  row_t        dir_tbl[$];
  tally_t      no_want;
  int unsigned pick;
  kind_e       rk;
  logic [7:0]  rpos;

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    kind_i = KIND_NOP;
    symbol_i = '0;
    position_i = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    tbl_total = 0;
    no_want = '{sym: 8'sd0, cnt: 32'd0, total: 9'd0, valid: 1'b0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes of symbol and position, ties in sort
    dir_tbl.push_back(mk(KIND_READ, 0, 0, 1, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_SORT, 0, 0, 1, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_NOP, -1, 255, 1, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_ADD, -128, 0, 1, -128, 1, 1, 1));
    dir_tbl.push_back(mk(KIND_ADD, 127, 0, 1, 127, 1, 2, 1));
    dir_tbl.push_back(mk(KIND_ADD, -128, 0, 1, -128, 2, 2, 1));
    dir_tbl.push_back(mk(KIND_ADD, 0, 0, 1, 0, 1, 3, 1));
    dir_tbl.push_back(mk(KIND_ADD, -1, 0, 1, -1, 1, 4, 1));
    dir_tbl.push_back(mk(KIND_READ, 0, 0, 1, -128, 2, 4, 1));
    dir_tbl.push_back(mk(KIND_READ, 0, 255, 1, 0, 0, 4, 0));
    dir_tbl.push_back(mk(KIND_READ, 0, 4, 1, 0, 0, 4, 0));
    dir_tbl.push_back(mk(KIND_NOP, 5, 1, 1, 0, 0, 4, 0));
    dir_tbl.push_back(mk(KIND_SORT, 0, 0, 1, 0, 0, 4, 0));
    for (int i = 0; i < 4; i++) dir_tbl.push_back(mk(KIND_READ, 0, i, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_ADD, 127, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_ADD, 127, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mk(KIND_SORT, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) dir_tbl.push_back(mk(KIND_READ, 0, i, 0, 0, 0, 0, 0));
    foreach (dir_tbl[i])
      send_item(dir_tbl[i].kind, dir_tbl[i].sym, dir_tbl[i].pos, dir_tbl[i].typed,
                dir_tbl[i].want);

    // Random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: send_idle_pct = 0;
        1: send_idle_pct = 61;
        2: send_idle_pct = 0;
        default: send_idle_pct = 23;
      endcase
      for (int n = 0; n < 41; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) rk = KIND_ADD;
        else if (pick < 90) rk = KIND_READ;
        else if (pick < 95) rk = KIND_SORT;
        else rk = KIND_NOP;
        // Mostly read live entries; sometimes any position
        if (tbl_total > 0 && $urandom_range(3) != 0) rpos = 8'($urandom_range(tbl_total - 1));
        else rpos = 8'($urandom_range(255));
        // Small symbol pool in early phases builds deep counts
        if (ph < 2 && $urandom_range(1) == 0)
          send_item(rk, 8'($urandom_range(7) - 4), rpos, 0, no_want);
        else
          send_item(rk, 8'($urandom_range(255)), rpos, 0, no_want);
      end
      // Fill the table with every symbol once, then add to a full table
      if (ph == 2) begin
        for (int s = 0; s < 256; s++) send_item(KIND_ADD, s[7:0], 0, 0, no_want);
        send_item(KIND_ADD, 8'($urandom_range(255)), 0, 0, no_want);
        send_item(KIND_READ, 0, 255, 0, no_want);
        send_item(KIND_SORT, 0, 0, 0, no_want);
        send_item(KIND_READ, 0, 0, 0, no_want);
        send_item(KIND_READ, 0, 255, 0, no_want);
      end
    end

    // Drain
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d adds, %0d sorts, %0d reads, %0d ignored kinds; %0d beats checked",
             n_add, n_sort, n_read, n_nop, n_beats);
    $display("Table ended with %0d distinct symbols after a full fill", tbl_total);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: symbol_frequency_table_sort_core.f
+incdir+rtl/core
rtl/core/sfts_pkg.sv
rtl/core/sfts_cell.sv
rtl/core/symbol_frequency_table_sort_core.sv
dv/symbol_frequency_table_sort_core_tb.sv
